[sv/mktc_pkg.sv]
`default_nettype none

package mktc_pkg;

	localparam int unsigned DB_W    = 10;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned EV_W    = 3;
	localparam int unsigned LAMP_W  = 4;
	localparam int unsigned PHASE_W = 2;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned CFG_W   = 16;

	localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [IDX_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [IDX_W-1:0] REG_SYMBOL_GAP = 2'd2;
	localparam logic [IDX_W-1:0] REG_WORD_GAP   = 2'd3;

	localparam logic [DB_W-1:0]   DEBOUNCE_RST   = 10'd50;
	localparam logic [TICK_W-1:0] LONG_PRESS_RST = 16'd300;
	localparam logic [TICK_W-1:0] SYMBOL_GAP_RST = 16'd1000;
	localparam logic [TICK_W-1:0] WORD_GAP_RST   = 16'd1000;

	localparam logic [PHASE_W-1:0] PHASE_PRESS  = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_SYMBOL = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_WORD   = 2'd2;

	localparam logic [TICK_W-1:0] PHASE_SPARE_LIMIT = 16'hFFFF;

	localparam logic [LAMP_W-1:0] LAMP_SHORT  = 4'b0001;
	localparam logic [LAMP_W-1:0] LAMP_LONG   = 4'b0010;
	localparam logic [LAMP_W-1:0] LAMP_SYMBOL = 4'b0100;
	localparam logic [LAMP_W-1:0] LAMP_WORD   = 4'b1000;

	localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
	localparam logic [EV_W-1:0] EV_SHORT  = 3'd1;
	localparam logic [EV_W-1:0] EV_LONG   = 3'd2;
	localparam logic [EV_W-1:0] EV_SYMBOL = 3'd3;
	localparam logic [EV_W-1:0] EV_WORD   = 3'd4;

	typedef struct packed {
		logic [DB_W-1:0]   debounce_count;
		logic [TICK_W-1:0] long_press_ticks;
		logic [TICK_W-1:0] symbol_gap_ticks;
		logic [TICK_W-1:0] word_gap_ticks;
	} cfg_t;

	typedef struct packed {
		logic [LAMP_W-1:0] lamps;
		logic [EV_W-1:0]   event_code;
	} result_t;

endpackage

`default_nettype wire

[sv/mktc_regs.sv]
`default_nettype none

module mktc_regs (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire  [mktc_pkg::IDX_W-1:0]    cfg_index,
	input  wire  [mktc_pkg::CFG_W-1:0]    cfg_data,
	output mktc_pkg::cfg_t                cfg
);

	mktc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_count   <= mktc_pkg::DEBOUNCE_RST;
			cfg_q.long_press_ticks <= mktc_pkg::LONG_PRESS_RST;
			cfg_q.symbol_gap_ticks <= mktc_pkg::SYMBOL_GAP_RST;
			cfg_q.word_gap_ticks   <= mktc_pkg::WORD_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mktc_pkg::REG_DEBOUNCE:   cfg_q.debounce_count   <= cfg_data[mktc_pkg::DB_W-1:0];
				mktc_pkg::REG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data;
				mktc_pkg::REG_SYMBOL_GAP: cfg_q.symbol_gap_ticks <= cfg_data;
				mktc_pkg::REG_WORD_GAP:   cfg_q.word_gap_ticks   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[sv/mktc_core.sv]
`default_nettype none

module mktc_core (
	input  wire                   clk,
	input  wire                   arst_n,
	input  mktc_pkg::cfg_t        cfg,
	input  wire                   step,
	input  wire                   key_level,
	input  wire                   tick,
	output mktc_pkg::result_t     result
);

	logic [mktc_pkg::DB_W-1:0]    high_q, low_q;
	logic                         down_q;
	logic [mktc_pkg::PHASE_W-1:0] phase_q;
	logic                         run_q;
	logic [mktc_pkg::TICK_W-1:0]  count_q;
	logic                         long_q;
	logic [mktc_pkg::LAMP_W-1:0]  lamp_q;

	logic [mktc_pkg::DB_W-1:0]    high_d, low_d, high_inc, low_inc;
	logic                         down_d;
	logic [mktc_pkg::PHASE_W-1:0] phase_d;
	logic                         run_d;
	logic [mktc_pkg::TICK_W-1:0]  count_d, count_inc, limit;
	logic                         long_d;
	logic [mktc_pkg::LAMP_W-1:0]  lamp_d;
	logic [mktc_pkg::EV_W-1:0]    ev;
	logic                         decided, pressed;

	always_comb begin
		high_d  = high_q;
		low_d   = low_q;
		down_d  = down_q;
		phase_d = phase_q;
		run_d   = run_q;
		count_d = count_q;
		long_d  = long_q;
		lamp_d  = lamp_q;
		ev      = mktc_pkg::EV_NONE;

		// timer first
		count_inc = count_q + 1'b1;
		case (phase_q)
			mktc_pkg::PHASE_PRESS:  limit = cfg.long_press_ticks;
			mktc_pkg::PHASE_SYMBOL: limit = cfg.symbol_gap_ticks;
			mktc_pkg::PHASE_WORD:   limit = cfg.word_gap_ticks;
			default:                limit = mktc_pkg::PHASE_SPARE_LIMIT;
		endcase
		if (tick && run_q) begin
			if (count_inc >= limit) begin
				count_d = '0;
				case (phase_q)
					mktc_pkg::PHASE_PRESS: begin
						long_d = 1'b1;
						lamp_d = mktc_pkg::LAMP_LONG;
					end
					mktc_pkg::PHASE_SYMBOL: begin
						ev      = mktc_pkg::EV_SYMBOL;
						lamp_d  = lamp_q | mktc_pkg::LAMP_SYMBOL;
						phase_d = mktc_pkg::PHASE_WORD;
					end
					mktc_pkg::PHASE_WORD: begin
						ev     = mktc_pkg::EV_WORD;
						lamp_d = (lamp_q & ~mktc_pkg::LAMP_SYMBOL) | mktc_pkg::LAMP_WORD;
						run_d  = 1'b0;
					end
					default: ;
				endcase
			end else begin
				count_d = count_inc;
			end
		end

		// then the key sample
		high_inc = high_q + 1'b1;
		low_inc  = low_q + 1'b1;
		if (key_level) begin
			high_d  = high_inc;
			decided = (high_inc >= cfg.debounce_count);
		end else begin
			low_d   = low_inc;
			decided = (low_inc >= cfg.debounce_count);
		end
		pressed = !key_level;
		if (decided) begin
			high_d = '0;
			low_d  = '0;
			if (pressed && !down_q) begin
				down_d  = 1'b1;
				phase_d = mktc_pkg::PHASE_PRESS;
				count_d = '0;
				run_d   = 1'b1;
				lamp_d  = mktc_pkg::LAMP_SHORT;
				long_d  = 1'b0;
			end else if (!pressed && down_q) begin
				down_d  = 1'b0;
				phase_d = mktc_pkg::PHASE_SYMBOL;
				count_d = '0;
				run_d   = 1'b1;
				ev      = long_d ? mktc_pkg::EV_LONG : mktc_pkg::EV_SHORT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q  <= '0;
			low_q   <= '0;
			down_q  <= 1'b0;
			phase_q <= mktc_pkg::PHASE_PRESS;
			run_q   <= 1'b0;
			count_q <= '0;
			long_q  <= 1'b0;
			lamp_q  <= '0;
		end else if (step) begin
			high_q  <= high_d;
			low_q   <= low_d;
			down_q  <= down_d;
			phase_q <= phase_d;
			run_q   <= run_d;
			count_q <= count_d;
			long_q  <= long_d;
			lamp_q  <= lamp_d;
		end
	end

	assign result.event_code = ev;
	assign result.lamps      = lamp_d;

endmodule

`default_nettype wire

[sv/mktc_out_buf.sv]
`default_nettype none

module mktc_out_buf (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  mktc_pkg::result_t     in_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output mktc_pkg::result_t     out_data
);

	logic              out_valid_q, skid_valid_q;
	mktc_pkg::result_t out_q, skid_q;
	logic              push, pop;

	assign in_ready = !skid_valid_q;
	assign push     = in_valid && in_ready;
	assign pop      = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (push) begin
			if (!out_valid_q || pop) out_q <= in_data;
			else skid_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// skid only ever holds a beat behind the output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid beat without output beat");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready && push))
		else $error("skid filled without stall");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled output beat lost");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && pop) |=> (!skid_valid_q && out_q == $past(skid_q)))
		else $error("skid beat not moved to output");

endmodule

`default_nettype wire

[sv/morse_key_timing_classifier.sv]
`default_nettype none

// channel  | dir | fields (low bit up)
// s_axis   | in  | tdata[0] key_level, [1] tick, [7:2] zero
// m_axis   | out | tdata[2:0] event_code, [6:3] lamps, [7] zero
// cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One beat in, one beat out; a beat can be taken every cycle while the skid stage is empty.
// Key and timer state update on the accepting edge; the result is registered at
// that same edge in an output register, with a one-beat skid stage behind it.
// s_tready drops only while the skid stage is full.
// Reset loads register defaults and clears all key, timer and lamp state.

module morse_key_timing_classifier (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [7:0]                   s_tdata,  // key_level, tick
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [7:0]                   m_tdata,  // event_code, lamps
	input  wire                          cfg_we,
	input  wire  [mktc_pkg::IDX_W-1:0]   cfg_index,
	input  wire  [mktc_pkg::CFG_W-1:0]   cfg_data
);

	mktc_pkg::cfg_t    cfg;
	mktc_pkg::result_t result, out_res;
	logic              step;

	assign step = s_tvalid && s_tready;

	mktc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mktc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.key_level (s_tdata[0]),
		.tick      (s_tdata[1]),
		.result    (result)
	);

	mktc_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (result),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {1'b0, out_res.lamps, out_res.event_code};

endmodule

`default_nettype wire
